### rtl/php_pkg.sv
package php_pkg;

	// width of a picture side and of its accumulator (one bit more for saturation)
	localparam int SIDE_BITS = 12;
	localparam int ACC_BITS  = SIDE_BITS + 1;
	localparam int PROD_BITS = ACC_BITS + 4;

	localparam logic [SIDE_BITS-1:0] MAX_SIDE_RESET = SIDE_BITS'(32'd4095);

	// queue depths between the parts
	localparam int QDEPTH    = 2;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// configuration register map
	localparam int PADDR_BITS = 3;
	localparam logic REG_MAX_SIDE = 1'b0;

	// character codes
	localparam logic [7:0] CH_P_UP   = 8'h50;
	localparam logic [7:0] CH_I_LOW  = 8'h69;
	localparam logic [7:0] CH_C_LOW  = 8'h63;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_X_LOW  = 8'h78;
	localparam logic [7:0] CH_C_UP   = 8'h43;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [3:0] {
		CLS_OTHER,
		CLS_DIGIT,
		CLS_P_UP,
		CLS_I_LOW,
		CLS_C_LOW,
		CLS_COLON,
		CLS_X_LOW,
		CLS_C_UP,
		CLS_SEMI
	} cls_t;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_WIDTH,
		PH_HEIGHT,
		PH_TAIL,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		MK_NONE,
		MK_P,
		MK_PI,
		MK_PIC
	} marker_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] digit;
		logic       last;
	} tok_t;

	typedef struct packed {
		logic                 verdict_ready;
		logic                 header_ok;
		logic [SIDE_BITS-1:0] pic_width;
		logic [SIDE_BITS-1:0] pic_height;
		logic                 is_color;
	} result_t;

	// queue handshake between front and back
	typedef struct packed {
		logic push;
		tok_t tok;
	} q_wr_t;

	typedef struct packed {
		logic empty;
		tok_t tok;
	} q_rd_t;

	// append one decimal digit, stopping at max_side + 1
	function automatic logic [ACC_BITS-1:0] sat_digit(
		input logic [ACC_BITS-1:0]  acc,
		input logic [3:0]           digit,
		input logic [SIDE_BITS-1:0] max_side
	);
		logic [ACC_BITS-1:0]  limit;
		logic [PROD_BITS-1:0] next;
		limit = {1'b0, max_side} + ACC_BITS'(1);
		next  = (PROD_BITS'(acc) << 3) + (PROD_BITS'(acc) << 1) + PROD_BITS'(digit);
		return (next > PROD_BITS'(limit)) ? limit : next[ACC_BITS-1:0];
	endfunction

endpackage

### rtl/picture_header_parser.sv
// Picture header recogniser for a character stream.
// Input channel: present char_code and end_of_text with push; a transfer
// happens at a rising edge with push high and full low. end_of_text marks
// the last character of a string, after which all parse state clears.
// Result channel: one result per character. While empty is low the oldest
// result sits on verdict_ready, header_ok, pic_width, pic_height and
// is_color; a transfer happens at a rising edge with pop high.
// A character's result passes through the classify register, the queue and
// the parser step into the result buffer before it is presented.
// Throughput: one character per cycle while results are popped, set by the
// parser step (digit times ten plus saturation); the front and back parts
// are joined by a two-entry queue and the results by a two-entry buffer.
// When pop stays low the result buffer fills, the parser holds, the queue
// fills and full rises; nothing is dropped. Reset clears all parse state
// and sets max_side to 4095. max_side is written over the APB port at byte
// address 0; the user must do so while the block is idle (not enforced).
module picture_header_parser
	import php_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            char_code,
	input  logic                  end_of_text,
	output logic                  empty,
	input  logic                  pop,
	output logic                  verdict_ready,
	output logic                  header_ok,
	output logic [SIDE_BITS-1:0]  pic_width,
	output logic [SIDE_BITS-1:0]  pic_height,
	output logic                  is_color,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	logic [SIDE_BITS-1:0] max_side_q;
	logic                 reg_sel;
	q_wr_t                q_wr;
	q_rd_t                q_rd;
	logic                 q_full;
	logic                 q_pop;
	result_t              res;

	// configuration register: word address taken from paddr[2]
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_MAX_SIDE);
	assign prdata  = reg_sel ? 32'(max_side_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_side_q <= MAX_SIDE_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_side_q <= pwdata[SIDE_BITS-1:0];
		end
	end

	// front: accept and classify each character
	php_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_wr        (q_wr)
	);

	// decouple classification from parsing
	php_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_rd   (q_rd)
	);

	// back: advance the parser and buffer its results
	php_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.max_side (max_side_q),
		.q_rd     (q_rd),
		.q_pop    (q_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign verdict_ready = res.verdict_ready;
	assign header_ok     = res.header_ok;
	assign pic_width     = res.pic_width;
	assign pic_height    = res.pic_height;
	assign is_color      = res.is_color;

endmodule

### rtl/php_front.sv
module php_front
	import php_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_code,
	input  logic       end_of_text,
	input  logic       q_full,
	output q_wr_t      q_wr
);

	logic valid_s1;
	tok_t tok_s1;
	tok_t tok_d;
	logic accept;

	// classify the character
	always_comb begin
		tok_d.last  = end_of_text;
		tok_d.digit = 4'(char_code - CH_ZERO);
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			tok_d.cls = CLS_DIGIT;
		end else begin
			case (char_code)
				CH_P_UP:  tok_d.cls = CLS_P_UP;
				CH_I_LOW: tok_d.cls = CLS_I_LOW;
				CH_C_LOW: tok_d.cls = CLS_C_LOW;
				CH_COLON: tok_d.cls = CLS_COLON;
				CH_X_LOW: tok_d.cls = CLS_X_LOW;
				CH_C_UP:  tok_d.cls = CLS_C_UP;
				CH_SEMI:  tok_d.cls = CLS_SEMI;
				default:  tok_d.cls = CLS_OTHER;
			endcase
		end
	end

	assign full        = valid_s1 & q_full;
	assign accept      = push & ~full;
	assign q_wr.push   = valid_s1 & ~q_full;
	assign q_wr.tok    = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr.push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tok_s1 <= tok_d;
		end
	end

endmodule

### rtl/php_queue.sv
module php_queue
	import php_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t q_wr,
	output logic  q_full,
	input  logic  q_pop,
	output q_rd_t q_rd
);

	tok_t                 mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_full     = (count_q == QCNT_BITS'(QDEPTH));
	assign q_rd.empty = (count_q == '0);
	assign q_rd.tok   = mem_q[rd_ptr_q];
	assign do_push    = q_wr.push & ~q_full;
	assign do_pop     = q_pop & ~q_rd.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_wr.tok;
		end
	end

endmodule

### rtl/php_back.sv
module php_back
	import php_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [SIDE_BITS-1:0] max_side,
	input  q_rd_t                q_rd,
	output logic                 q_pop,
	input  logic                 pop,
	output logic                 empty,
	output result_t              res
);

	phase_t              phase_q, phase_d;
	marker_t             marker_q, marker_d;
	logic [ACC_BITS-1:0] width_q, width_d;
	logic [ACC_BITS-1:0] height_q, height_d;
	logic                color_q, color_d;

	result_t              res_d;
	result_t              ob_q [QDEPTH];
	logic [QPTR_BITS-1:0] ob_wr_q;
	logic [QPTR_BITS-1:0] ob_rd_q;
	logic [QCNT_BITS-1:0] ob_cnt_q;
	logic                 ob_full;
	logic                 ob_pop;

	tok_t                tok;
	logic                step;
	logic                judge_ok;
	logic [ACC_BITS-1:0] width_add;
	logic [ACC_BITS-1:0] height_add;
	cls_t                expect_cls;

	assign tok     = q_rd.tok;
	assign ob_full = (ob_cnt_q == QCNT_BITS'(QDEPTH));
	assign step    = ~q_rd.empty & ~ob_full;
	assign q_pop   = step;

	assign width_add  = sat_digit(width_q, tok.digit, max_side);
	assign height_add = sat_digit(height_q, tok.digit, max_side);
	assign judge_ok   = (width_q != '0) && (height_q != '0) &&
	                    (width_q <= {1'b0, max_side}) && (height_q <= {1'b0, max_side});

	always_comb begin
		case (marker_q)
			MK_NONE: expect_cls = CLS_P_UP;
			MK_P:    expect_cls = CLS_I_LOW;
			MK_PI:   expect_cls = CLS_C_LOW;
			MK_PIC:  expect_cls = CLS_COLON;
			default: expect_cls = CLS_P_UP;
		endcase
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		marker_d = marker_q;
		width_d  = width_q;
		height_d = height_q;
		color_d  = color_q;
		case (phase_q)
			PH_SEARCH: begin
				if (tok.cls == expect_cls) begin
					if (marker_q == MK_PIC) begin
						marker_d = MK_NONE;
						phase_d  = PH_WIDTH;
					end else begin
						marker_d = marker_t'(marker_q + 2'd1);
					end
				end else begin
					marker_d = (tok.cls == CLS_P_UP) ? MK_P : MK_NONE;
				end
			end
			PH_WIDTH: begin
				if (tok.cls == CLS_DIGIT) begin
					width_d = width_add;
				end else if (tok.cls == CLS_X_LOW) begin
					phase_d = PH_HEIGHT;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_HEIGHT: begin
				if (tok.cls == CLS_DIGIT) begin
					height_d = height_add;
				end else if (tok.cls == CLS_C_UP) begin
					color_d = 1'b1;
					phase_d = PH_TAIL;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_TAIL: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
		if (tok.last) begin
			phase_d  = PH_SEARCH;
			marker_d = MK_NONE;
			width_d  = '0;
			height_d = '0;
			color_d  = 1'b0;
		end
	end

	// result of this character
	always_comb begin
		res_d = '0;
		case (phase_q)
			PH_WIDTH: begin
				if (tok.cls != CLS_DIGIT && tok.cls != CLS_X_LOW) begin
					res_d.verdict_ready = 1'b1;
				end
			end
			PH_HEIGHT, PH_TAIL: begin
				if (tok.cls == CLS_SEMI) begin
					res_d.verdict_ready = 1'b1;
					res_d.header_ok     = judge_ok;
					res_d.pic_width     = judge_ok ? width_q[SIDE_BITS-1:0] : '0;
					res_d.pic_height    = judge_ok ? height_q[SIDE_BITS-1:0] : '0;
					res_d.is_color      = judge_ok & color_q;
				end else if (phase_q == PH_TAIL ||
				             (tok.cls != CLS_DIGIT && tok.cls != CLS_C_UP)) begin
					res_d.verdict_ready = 1'b1;
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
		if (tok.last && phase_q != PH_DONE) begin
			res_d.verdict_ready = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			marker_q <= MK_NONE;
			width_q  <= '0;
			height_q <= '0;
			color_q  <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			marker_q <= marker_d;
			width_q  <= width_d;
			height_q <= height_d;
			color_q  <= color_d;
		end
	end

	// result buffer
	assign empty  = (ob_cnt_q == '0);
	assign res    = ob_q[ob_rd_q];
	assign ob_pop = pop & ~empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= '0;
			ob_rd_q  <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (step) begin
				ob_wr_q <= (ob_wr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : ob_wr_q + 1'b1;
			end
			if (ob_pop) begin
				ob_rd_q <= (ob_rd_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : ob_rd_q + 1'b1;
			end
			case ({step, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 1'b1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 1'b1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ob_q[ob_wr_q] <= res_d;
		end
	end

endmodule
